### design/text_console_writer_assert.svh
// Assertion macros shared by the console writer's assertion blocks.
`ifndef TEXT_CONSOLE_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define TCW_ASSERT_HOLDS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define TCW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/tcw_pkg.sv
// Shared types and constants of the text console writer.
package tcw_pkg;

  localparam int CHAR_W       = 8;
  localparam int ATTR_W       = 8;
  localparam int CELL_W       = CHAR_W + ATTR_W;
  localparam int CMD_W        = 2;
  localparam int IN_ROW_W     = 5;
  localparam int IN_COL_W     = 7;
  localparam int CURSOR_ROW_W = 5;
  localparam int CURSOR_COL_W = 7;

  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h08;

  localparam logic [CHAR_W-1:0] CHAR_NUL = 8'd0;
  localparam logic [CHAR_W-1:0] CHAR_LF  = 8'd10;
  localparam logic [CHAR_W-1:0] CHAR_CR  = 8'd13;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUT    = 2'd0,
    CMD_CLEAR  = 2'd1,
    CMD_READ   = 2'd2,
    CMD_UNUSED = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_CR,
    OP_LF,
    OP_PUT,
    OP_CLEAR,
    OP_READ
  } op_kind_t;

  typedef struct packed {
    op_kind_t              kind;
    logic [CHAR_W-1:0]     char_code;
    logic [IN_ROW_W-1:0]   row;
    logic [IN_COL_W-1:0]   col;
  } tcw_op_t;

  typedef struct packed {
    logic not_empty;
    logic full;
  } tcw_qstat_t;

  typedef enum logic [2:0] {
    BK_INIT,
    BK_IDLE,
    BK_CLEAR,
    BK_SCROLL,
    BK_SCROLL_END,
    BK_PUT,
    BK_REPLY
  } bk_state_t;

endpackage

### design/tcw_front.sv
// Front end: accepts input items and classifies them into queue operations.
module tcw_front #(
  parameter int SCREEN_COLUMNS = 80,
  parameter int SCREEN_ROWS    = 25
) (
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [tcw_pkg::CMD_W-1:0]       cmd,
  input  logic [tcw_pkg::CHAR_W-1:0]      char_code,
  input  logic [tcw_pkg::IN_ROW_W-1:0]    cell_row,
  input  logic [tcw_pkg::IN_COL_W-1:0]    cell_col,
  input  logic                            hold,
  input  tcw_pkg::tcw_qstat_t             q_stat,
  output logic                            push,
  output tcw_pkg::tcw_op_t                op
);
  import tcw_pkg::*;

  logic in_range;

  assign in_stall = hold || q_stat.full;
  assign push     = in_valid && !in_stall;
  assign in_range = (int'(cell_row) < SCREEN_ROWS) && (int'(cell_col) < SCREEN_COLUMNS);

  always_comb begin
    op.char_code = char_code;
    op.row       = cell_row;
    op.col       = cell_col;
    unique case (cmd)
      CMD_PUT: begin
        priority if (char_code == CHAR_NUL) op.kind = OP_NOP;
        else if (char_code == CHAR_CR)      op.kind = OP_CR;
        else if (char_code == CHAR_LF)      op.kind = OP_LF;
        else                                op.kind = OP_PUT;
      end
      CMD_CLEAR: op.kind = OP_CLEAR;
      // out-of-range reads answer zero, same as an ignored item
      CMD_READ:  op.kind = in_range ? OP_READ : OP_NOP;
      default:   op.kind = OP_NOP;
    endcase
  end

endmodule

### design/tcw_queue.sv
// Short queue of classified operations between front and back.
module tcw_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  tcw_pkg::tcw_op_t     push_op,
  input  logic                 pop,
  output tcw_pkg::tcw_op_t     head,
  output tcw_pkg::tcw_qstat_t  q_stat
);
  import tcw_pkg::*;

  tcw_op_t           entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign head             = entries[rd_ptr];
  assign q_stat.not_empty = (count != '0);
  assign q_stat.full      = (count == QCNT_W'(QUEUE_DEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

### design/tcw_back.sv
// Back end: screen store, cursor, scroll and clear sequencer, result register.
module tcw_back #(
  parameter int SCREEN_COLUMNS = 80,
  parameter int SCREEN_ROWS    = 25,
  parameter int SCROLL_LIMIT   = 23
) (
  input  logic                                clk,
  input  logic                                rst,
  input  tcw_pkg::tcw_op_t                    head,
  input  tcw_pkg::tcw_qstat_t                 q_stat,
  output logic                                pop,
  input  logic [tcw_pkg::ATTR_W-1:0]          attr,
  output logic                                init_busy,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [tcw_pkg::CHAR_W-1:0]          cell_char,
  output logic [tcw_pkg::ATTR_W-1:0]          cell_attr,
  output logic [tcw_pkg::CURSOR_ROW_W-1:0]    cursor_row,
  output logic [tcw_pkg::CURSOR_COL_W-1:0]    cursor_col
);
  import tcw_pkg::*;

  localparam int CELLS  = SCREEN_ROWS * SCREEN_COLUMNS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int ROW_W  = $clog2(SCREEN_ROWS);
  localparam int COL_W  = $clog2(SCREEN_COLUMNS);
  localparam int COPY_CELLS = SCROLL_LIMIT * SCREEN_COLUMNS;
  localparam logic [ADDR_W-1:0] LAST_CELL   = ADDR_W'(CELLS - 1);
  localparam logic [ADDR_W-1:0] LAST_SCROLL =
    ADDR_W'((SCROLL_LIMIT + 1) * SCREEN_COLUMNS - 1);

  logic [CELL_W-1:0] mem [CELLS];

  bk_state_t         state, state_next;
  logic [ADDR_W-1:0] scan, scan_next;
  logic [ROW_W-1:0]  cur_row, cur_row_next;
  logic [COL_W-1:0]  cur_col, cur_col_next;
  logic [CHAR_W-1:0] cur_char, cur_char_next;
  logic              reply_read, reply_read_next;
  logic              wr_pending, wr_pending_next;
  logic [ADDR_W-1:0] wr_addr, wr_addr_next;
  logic              wr_blank, wr_blank_next;
  logic [CELL_W-1:0] rd_data;
  logic              out_valid_next;
  logic [CHAR_W-1:0] cell_char_next;
  logic [ATTR_W-1:0] cell_attr_next;
  logic [CURSOR_ROW_W-1:0] cursor_row_next;
  logic [CURSOR_COL_W-1:0] cursor_col_next;

  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [CELL_W-1:0] mem_wdata;

  logic              slot_free;
  logic              need_scroll;
  logic [ADDR_W-1:0] cursor_addr;
  logic [ADDR_W-1:0] read_addr;
  logic [ROW_W-1:0]  row_down;
  logic [COL_W-1:0]  col_adv;
  logic [ROW_W-1:0]  row_adv;

  assign init_busy   = (state == BK_INIT);
  assign slot_free   = !out_valid || !out_stall;
  assign need_scroll = (int'(cur_row) >= SCROLL_LIMIT);
  assign cursor_addr = ADDR_W'(int'(cur_row) * SCREEN_COLUMNS + int'(cur_col));
  assign read_addr   = ADDR_W'(int'(head.row) * SCREEN_COLUMNS + int'(head.col));
  assign row_down    = (int'(cur_row) + 1 < SCREEN_ROWS) ? cur_row + ROW_W'(1) : cur_row;
  assign col_adv     = (int'(cur_col) + 1 >= SCREEN_COLUMNS) ? '0 : cur_col + COL_W'(1);
  assign row_adv     = (int'(cur_col) + 1 >= SCREEN_COLUMNS) ? row_down : cur_row;

  always_comb begin
    state_next = state;
    unique case (state)
      BK_INIT:  if (scan == LAST_CELL) state_next = BK_IDLE;
      BK_CLEAR: if (scan == LAST_CELL) state_next = BK_REPLY;
      BK_IDLE: begin
        if (q_stat.not_empty) begin
          unique case (head.kind)
            OP_CLEAR: state_next = BK_CLEAR;
            OP_PUT:   state_next = need_scroll ? BK_SCROLL : BK_REPLY;
            default:  state_next = BK_REPLY;
          endcase
        end
      end
      BK_SCROLL: if (scan == LAST_SCROLL) state_next = BK_SCROLL_END;
      // scroll again while the row after this pass still sits at the limit
      BK_SCROLL_END: state_next = (int'(cur_row) > SCROLL_LIMIT) ? BK_SCROLL : BK_PUT;
      BK_PUT:   state_next = BK_REPLY;
      BK_REPLY: if (slot_free) state_next = BK_IDLE;
      default:  state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    mem_we          = wr_pending;
    mem_waddr       = wr_addr;
    mem_wdata       = wr_blank ? {rd_data[CELL_W-1:CHAR_W], CHAR_NUL} : rd_data;
    mem_re          = 1'b0;
    mem_raddr       = '0;
    pop             = 1'b0;
    scan_next       = scan;
    cur_row_next    = cur_row;
    cur_col_next    = cur_col;
    cur_char_next   = cur_char;
    reply_read_next = reply_read;
    wr_pending_next = 1'b0;
    wr_addr_next    = wr_addr;
    wr_blank_next   = wr_blank;
    out_valid_next  = out_valid && out_stall;
    cell_char_next  = cell_char;
    cell_attr_next  = cell_attr;
    cursor_row_next = cursor_row;
    cursor_col_next = cursor_col;
    unique case (state)
      BK_INIT, BK_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = scan;
        mem_wdata = '0;
        scan_next = (scan == LAST_CELL) ? '0 : scan + ADDR_W'(1);
      end
      BK_IDLE: begin
        if (q_stat.not_empty) begin
          pop             = 1'b1;
          reply_read_next = (head.kind == OP_READ);
          cur_char_next   = head.char_code;
          unique case (head.kind)
            OP_CR: cur_col_next = '0;
            OP_LF: begin
              cur_col_next = '0;
              cur_row_next = row_down;
            end
            OP_PUT: begin
              scan_next = '0;
              if (!need_scroll) begin
                mem_we       = 1'b1;
                mem_waddr    = cursor_addr;
                mem_wdata    = {attr, head.char_code};
                cur_col_next = col_adv;
                cur_row_next = row_adv;
              end
            end
            OP_CLEAR: begin
              scan_next    = '0;
              cur_row_next = '0;
              cur_col_next = '0;
            end
            OP_READ: begin
              mem_re    = 1'b1;
              mem_raddr = read_addr;
            end
            default: ;
          endcase
        end
      end
      BK_SCROLL: begin
        // read one row below for the copy, the cell itself for the blanking row
        mem_re          = 1'b1;
        mem_raddr       = (int'(scan) < COPY_CELLS) ?
                          ADDR_W'(int'(scan) + SCREEN_COLUMNS) : scan;
        wr_pending_next = 1'b1;
        wr_addr_next    = scan;
        wr_blank_next   = (int'(scan) >= COPY_CELLS);
        scan_next       = (scan == LAST_SCROLL) ? '0 : scan + ADDR_W'(1);
      end
      BK_SCROLL_END: cur_row_next = cur_row - ROW_W'(1);
      BK_PUT: begin
        mem_we       = 1'b1;
        mem_waddr    = cursor_addr;
        mem_wdata    = {attr, cur_char};
        cur_col_next = col_adv;
        cur_row_next = row_adv;
      end
      BK_REPLY: begin
        if (slot_free) begin
          out_valid_next  = 1'b1;
          cell_char_next  = reply_read ? rd_data[CHAR_W-1:0] : '0;
          cell_attr_next  = reply_read ? rd_data[CELL_W-1:CHAR_W] : '0;
          cursor_row_next = CURSOR_ROW_W'(cur_row);
          cursor_col_next = CURSOR_COL_W'(cur_col);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= BK_INIT;
      scan       <= '0;
      cur_row    <= '0;
      cur_col    <= '0;
      reply_read <= 1'b0;
      wr_pending <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      scan       <= scan_next;
      cur_row    <= cur_row_next;
      cur_col    <= cur_col_next;
      reply_read <= reply_read_next;
      wr_pending <= wr_pending_next;
      out_valid  <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    cur_char   <= cur_char_next;
    wr_addr    <= wr_addr_next;
    wr_blank   <= wr_blank_next;
    cell_char  <= cell_char_next;
    cell_attr  <= cell_attr_next;
    cursor_row <= cursor_row_next;
    cursor_col <= cursor_col_next;
  end

endmodule

### design/text_console_writer.sv
// Top level of the text console writer: front, queue, back and attribute register.
//
// Input channel (in_valid / in_stall): one item per command. cmd 0 puts
// char_code at the cursor (carriage return, line feed and null are handled),
// cmd 1 clears the screen, cmd 2 reads the cell at cell_row / cell_col.
// Output channel (out_valid / out_stall): exactly one item per input item,
// in order, carrying the read cell (zero unless a read) and the cursor after it.
// Config: cfg_we writes cfg_wdata into the attribute byte stored with each
// character; write only while the block is idle. Reset value is 0x08.
// Back end: put, return, line feed, read and ignored items pass its dispatch
// state, then its result register. A put at or below the scroll limit row
// first scrolls: each pass walks (SCROLL_LIMIT+1)*SCREEN_COLUMNS cells
// through the store's read and write ports and then moves the cursor up a
// row; the put state then writes the character. A clear sweeps all
// SCREEN_ROWS*SCREEN_COLUMNS cells, one per cycle, then replies.
// Reset: the screen store is swept to zero, one cell per cycle; in_stall is
// held high until the sweep ends. A two-entry queue lets the front keep
// accepting items while the back works or the receiver stalls; a stalled
// result holds.
module text_console_writer #(
  parameter int SCREEN_COLUMNS = 80,
  parameter int SCREEN_ROWS    = 25,
  parameter int SCROLL_LIMIT   = 23
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [tcw_pkg::ATTR_W-1:0]          cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [tcw_pkg::CMD_W-1:0]           cmd,
  input  logic [tcw_pkg::CHAR_W-1:0]          char_code,
  input  logic [tcw_pkg::IN_ROW_W-1:0]        cell_row,
  input  logic [tcw_pkg::IN_COL_W-1:0]        cell_col,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [tcw_pkg::CHAR_W-1:0]          cell_char,
  output logic [tcw_pkg::ATTR_W-1:0]          cell_attr,
  output logic [tcw_pkg::CURSOR_ROW_W-1:0]    cursor_row,
  output logic [tcw_pkg::CURSOR_COL_W-1:0]    cursor_col
);
  import tcw_pkg::*;

  // attribute byte applied to every written character
  logic [ATTR_W-1:0] attr;

  // front to queue
  logic       q_push;
  tcw_op_t    q_push_op;
  // queue to back
  tcw_op_t    q_head;
  tcw_qstat_t q_stat;
  logic       q_pop;
  // back is sweeping the store after reset: hold the input side
  logic       init_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      attr <= ATTR_RESET;
    end else if (cfg_we) begin
      attr <= cfg_wdata;
    end
  end

  tcw_front #(
    .SCREEN_COLUMNS (SCREEN_COLUMNS),
    .SCREEN_ROWS    (SCREEN_ROWS)
  ) u_front (
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cmd       (cmd),
    .char_code (char_code),
    .cell_row  (cell_row),
    .cell_col  (cell_col),
    .hold      (init_busy),
    .q_stat    (q_stat),
    .push      (q_push),
    .op        (q_push_op)
  );

  tcw_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .push_op (q_push_op),
    .pop     (q_pop),
    .head    (q_head),
    .q_stat  (q_stat)
  );

  tcw_back #(
    .SCREEN_COLUMNS (SCREEN_COLUMNS),
    .SCREEN_ROWS    (SCREEN_ROWS),
    .SCROLL_LIMIT   (SCROLL_LIMIT)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (q_head),
    .q_stat     (q_stat),
    .pop        (q_pop),
    .attr       (attr),
    .init_busy  (init_busy),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .cell_char  (cell_char),
    .cell_attr  (cell_attr),
    .cursor_row (cursor_row),
    .cursor_col (cursor_col)
  );

`include "text_console_writer_assert.svh"

  // no result may appear while the store is still being swept after reset
  `TCW_ASSERT_HOLDS(a_no_result_in_init, init_busy, !out_valid, "result during init sweep")
  // nothing is taken in during the sweep, so the queue is empty when it ends
  `TCW_ASSERT_HOLDS(a_queue_empty_after_init, $fell(init_busy), !q_stat.not_empty, "item queued during init")
  // the back end only pops a real entry
  `TCW_ASSERT_HOLDS(a_pop_not_empty, q_pop, q_stat.not_empty, "pop from empty queue")
  // an accepted item is waiting in the queue on the next cycle
  `TCW_ASSERT_NEXT(a_accept_queued, in_valid && !in_stall, q_stat.not_empty, "accepted item lost")

endmodule
